// ===== rtl/rcd_pkg.sv =====
// Shared types and constants of the resyncing command deframer.
`default_nettype none

package rcd_pkg;

	localparam int HDR_BYTES   = 3;
	localparam int MAX_PAYLOAD = 61;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SET_PROFILE_ID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GET_STATUS_ID  = 2'd2;

	localparam logic [7:0] SYNC_BYTE_RST      = 8'd90;
	localparam logic [7:0] SET_PROFILE_ID_RST = 8'd1;
	localparam logic [7:0] GET_STATUS_ID_RST  = 8'd2;

	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_word_t;

	typedef struct packed {
		logic       command_kind;
		logic [5:0] payload_length;
		logic [7:0] payload_byte;
		logic [5:0] byte_index;
		logic       last;
	} cmd_word_t;

	typedef enum logic [2:0] {
		RD_HEAD,
		RD_LEN,
		RD_CMD,
		RD_FIRST,
		RD_NEXT
	} rd_sel_t;

	typedef struct packed {
		logic    push;
		logic    drop_one;
		logic    drop_frame;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    cap_plen;
		logic    cap_kind;
		logic    k_clr;
		logic    k_inc;
		logic    load_pay;
		logic    load_empty;
	} ctrl_cmd_t;

	typedef struct packed {
		logic fill_zero;
		logic fill_lt3;
		logic is_sync;
		logic cmd_match;
		logic len_bad;
		logic frame_short;
		logic plen_zero;
		logic k_last;
		logic out_free;
	} ctrl_stat_t;

endpackage

`default_nettype wire

// ===== rtl/rcd_stream_if.sv =====
// Valid/ready channel interface carrying one word per handshake.
`default_nettype none

interface rcd_stream_if #(
	parameter type word_t = logic
) ();
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rcd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/rcd_dpath.sv =====
// Datapath: circular byte store, header fields, configuration and result register.
`default_nettype none

module rcd_dpath #(
	parameter int STORE_DEPTH = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [rcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rcd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire rcd_pkg::rx_word_t              rx_word,
	input  wire rcd_pkg::ctrl_cmd_t             cmd,
	output rcd_pkg::ctrl_stat_t                 stat,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output rcd_pkg::cmd_word_t                  out_word
);

	localparam int PW = $clog2(STORE_DEPTH);
	localparam int FW = $clog2(STORE_DEPTH + 1);
	localparam int CW = (FW > 8) ? FW + 1 : 10;

	logic [7:0]    sync_q;
	logic [7:0]    set_id_q;
	logic [7:0]    get_id_q;
	logic [PW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic [7:0]    plen_q;
	logic          kind_q;
	logic [5:0]    k_q;
	logic          out_valid_q;
	rcd_pkg::cmd_word_t out_q;

	logic          fill_full;
	logic [PW-1:0] waddr;
	logic [PW-1:0] raddr;
	logic [FW-1:0] rd_off;
	logic [7:0]    rdata;
	logic [FW-1:0] frame_len;
	logic          k_last;

	function automatic logic [PW-1:0] wrap(input logic [PW-1:0] base, input logic [FW-1:0] off);
		logic [FW:0] s;
		s = (FW+1)'(base) + (FW+1)'(off);
		if (s >= (FW+1)'(STORE_DEPTH)) begin
			s = s - (FW+1)'(STORE_DEPTH);
		end
		return s[PW-1:0];
	endfunction

	assign fill_full = (fill_q == FW'(STORE_DEPTH));
	assign waddr     = fill_full ? head_q : wrap(head_q, fill_q);
	assign frame_len = FW'(9'(plen_q) + 9'(rcd_pkg::HDR_BYTES));
	assign k_last    = ((7'(k_q) + 7'd1) == 7'(plen_q[5:0]));

	always_comb begin
		case (cmd.rd_sel)
			rcd_pkg::RD_HEAD:  rd_off = '0;
			rcd_pkg::RD_LEN:   rd_off = FW'(1);
			rcd_pkg::RD_CMD:   rd_off = FW'(2);
			rcd_pkg::RD_FIRST: rd_off = FW'(rcd_pkg::HDR_BYTES);
			rcd_pkg::RD_NEXT:  rd_off = FW'(7'(k_q) + 7'd4);
			default:           rd_off = '0;
		endcase
	end

	assign raddr = wrap(head_q, rd_off);

	rcd_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (waddr),
		.wdata (rx_word.rx_byte),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		stat.fill_zero   = (fill_q == '0);
		stat.fill_lt3    = (fill_q < FW'(rcd_pkg::HDR_BYTES));
		stat.is_sync     = (rdata == sync_q);
		stat.cmd_match   = (rdata == set_id_q) || (rdata == get_id_q);
		stat.len_bad     = (plen_q > 8'(rcd_pkg::MAX_PAYLOAD));
		stat.frame_short = (CW'(fill_q) < (CW'(plen_q) + CW'(rcd_pkg::HDR_BYTES)));
		stat.plen_zero   = (plen_q == '0);
		stat.k_last      = k_last;
		stat.out_free    = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q   <= rcd_pkg::SYNC_BYTE_RST;
			set_id_q <= rcd_pkg::SET_PROFILE_ID_RST;
			get_id_q <= rcd_pkg::GET_STATUS_ID_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rcd_pkg::REG_SYNC_BYTE:      sync_q   <= cfg_data;
				rcd_pkg::REG_SET_PROFILE_ID: set_id_q <= cfg_data;
				rcd_pkg::REG_GET_STATUS_ID:  get_id_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else begin
			if (cmd.push) begin
				if (fill_full) begin
					head_q <= wrap(head_q, FW'(1));
				end else begin
					fill_q <= fill_q + FW'(1);
				end
			end
			if (cmd.drop_one) begin
				head_q <= wrap(head_q, FW'(1));
				fill_q <= fill_q - FW'(1);
			end
			if (cmd.drop_frame) begin
				head_q <= wrap(head_q, frame_len);
				fill_q <= fill_q - frame_len;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_plen) begin
			plen_q <= rdata;
		end
		if (cmd.cap_kind) begin
			kind_q <= (rdata != set_id_q);
		end
		if (cmd.k_clr) begin
			k_q <= '0;
		end else if (cmd.k_inc) begin
			k_q <= k_q + 6'd1;
		end
		if (cmd.load_pay) begin
			out_q.command_kind   <= kind_q;
			out_q.payload_length <= plen_q[5:0];
			out_q.payload_byte   <= rdata;
			out_q.byte_index     <= k_q;
			out_q.last           <= k_last;
		end else if (cmd.load_empty) begin
			out_q.command_kind   <= kind_q;
			out_q.payload_length <= '0;
			out_q.payload_byte   <= '0;
			out_q.byte_index     <= '0;
			out_q.last           <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_pay || cmd.load_empty) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

`default_nettype wire

// ===== rtl/rcd_ctrl.sv =====
// Controller: sequences store push, front rescan, header check and result emission.
`default_nettype none

module rcd_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                rx_valid,
	output logic                     rx_ready,
	input  wire rcd_pkg::ctrl_stat_t stat,
	output rcd_pkg::ctrl_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_PAY,
		ST_EMPTY
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd      = '0;
		cmd.rd_sel = rcd_pkg::RD_HEAD;
		rx_ready = 1'b0;
		state_d  = state_q;
		case (state_q)
			ST_IDLE: begin
				rx_ready = 1'b1;
				if (rx_valid) begin
					cmd.push = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.fill_zero) begin
					state_d = ST_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = rcd_pkg::RD_HEAD;
					state_d    = ST_RD0;
				end
			end
			ST_RD0: begin
				if (!stat.is_sync) begin
					cmd.drop_one = 1'b1;
					state_d      = ST_SCAN;
				end else if (stat.fill_lt3) begin
					state_d = ST_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = rcd_pkg::RD_LEN;
					state_d    = ST_RD1;
				end
			end
			ST_RD1: begin
				cmd.cap_plen = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = rcd_pkg::RD_CMD;
				state_d      = ST_RD2;
			end
			ST_RD2: begin
				if (!stat.cmd_match) begin
					cmd.drop_one = 1'b1;
					state_d      = ST_SCAN;
				end else if (stat.len_bad || stat.frame_short) begin
					state_d = ST_IDLE;
				end else if (stat.plen_zero) begin
					cmd.cap_kind = 1'b1;
					state_d      = ST_EMPTY;
				end else begin
					cmd.cap_kind = 1'b1;
					cmd.k_clr    = 1'b1;
					cmd.rd_en    = 1'b1;
					cmd.rd_sel   = rcd_pkg::RD_FIRST;
					state_d      = ST_PAY;
				end
			end
			ST_PAY: begin
				if (stat.out_free) begin
					cmd.load_pay = 1'b1;
					if (stat.k_last) begin
						cmd.drop_frame = 1'b1;
						state_d        = ST_IDLE;
					end else begin
						cmd.k_inc  = 1'b1;
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = rcd_pkg::RD_NEXT;
					end
				end
			end
			ST_EMPTY: begin
				if (stat.out_free) begin
					cmd.load_empty = 1'b1;
					cmd.drop_frame = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/resyncing_command_deframer.sv =====
// Top level of the resyncing command deframer.
// Channel rx takes one received byte per word; channel cmd returns command words,
// one per payload byte, or a single word with zero byte and index for an empty
// payload, with last set on the final word of each command.
// Write configuration registers (sync byte, set profile id, get status id) via
// cfg_we, cfg_index and cfg_data only while idle; the block does not enforce it.
// Bytes live in a circular store of STORE_DEPTH entries; when it is full, the
// oldest byte is dropped before the new one is stored.
// After a byte is accepted, the controller rescans the front of the store, one
// RAM read at a time: a non-sync byte at the front is read and dropped; a sync
// byte is followed by reads of the length and command id bytes and is dropped
// if the id is unknown; a complete header leads to one payload word per cycle
// while cmd is ready. The store has a single read port and the result register
// holds one word.
// rx is ready again once the scan ends; the final word of a command may still
// wait in the result register while the next byte is taken.
// When cmd stalls, the controller holds its place and the current word stays.
// Reset empties the store and loads the register defaults; stored bytes need no
// clearing since only written entries are read.
`default_nettype none

module resyncing_command_deframer #(
	parameter int STORE_DEPTH = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [rcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rcd_pkg::CFG_DATA_W-1:0] cfg_data,
	rcd_stream_if.sink                          rx,
	rcd_stream_if.source                        cmd
);

	rcd_pkg::ctrl_cmd_t  ctrl_cmd;
	rcd_pkg::ctrl_stat_t ctrl_stat;
	rcd_pkg::rx_word_t   rx_word;
	rcd_pkg::cmd_word_t  out_word;
	logic                rx_ready;
	logic                out_valid;

	assign rx_word  = rx.data;
	assign rx.ready = rx_ready;

	rcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx.valid),
		.rx_ready (rx_ready),
		.stat     (ctrl_stat),
		.cmd      (ctrl_cmd)
	);

	rcd_dpath #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx_word   (rx_word),
		.cmd       (ctrl_cmd),
		.stat      (ctrl_stat),
		.out_valid (out_valid),
		.out_ready (cmd.ready),
		.out_word  (out_word)
	);

	assign cmd.valid = out_valid;
	assign cmd.data  = out_word;

endmodule

`default_nettype wire

// ===== rtl/rcd_checker.sv =====
// Port-level checker for the resyncing command deframer and its bind.
`default_nettype none

module rcd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rx_valid,
	input wire logic       rx_ready,
	input wire logic       cmd_valid,
	input wire logic       cmd_ready,
	input wire logic [5:0] cmd_payload_length,
	input wire logic [7:0] cmd_payload_byte,
	input wire logic [5:0] cmd_byte_index,
	input wire logic       cmd_last
);

	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid)
		else $error("cmd word dropped while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		rx_valid && rx_ready |=> !rx_ready)
		else $error("rx ready right after a byte was taken");

	a_no_rx_mid_command: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_last |-> !rx_ready)
		else $error("rx ready while a command is being emitted");

	a_last_position: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && (cmd_payload_length != 6'd0) |->
			(cmd_last == (cmd_byte_index == (cmd_payload_length - 6'd1))))
		else $error("last flag does not match byte position");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && (cmd_payload_length == 6'd0) |->
			cmd_last && (cmd_byte_index == 6'd0) && (cmd_payload_byte == 8'd0))
		else $error("empty command word malformed");

endmodule

bind resyncing_command_deframer rcd_checker u_rcd_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.rx_valid           (rx.valid),
	.rx_ready           (rx.ready),
	.cmd_valid          (cmd.valid),
	.cmd_ready          (cmd.ready),
	.cmd_payload_length (cmd.data.payload_length),
	.cmd_payload_byte   (cmd.data.payload_byte),
	.cmd_byte_index     (cmd.data.byte_index),
	.cmd_last           (cmd.data.last)
);

`default_nettype wire
